### rtl/ptsc_pkg.sv
`default_nettype none

package ptsc_pkg;

    // SNR table geometry
    localparam int SNR_TABLE_DEPTH = 1024;
    localparam int SPAN_Q8         = 8192;
    localparam int FRAC_W          = $clog2(SPAN_Q8);
    localparam int IDX_W           = $clog2(SNR_TABLE_DEPTH);
    localparam int POS_W           = FRAC_W + IDX_W;
    localparam int EVEN_DEPTH      = SNR_TABLE_DEPTH / 2 + 1;
    localparam int ODD_DEPTH       = (SNR_TABLE_DEPTH + 1) / 2;
    localparam int EVEN_AW         = $clog2(EVEN_DEPTH);
    localparam int ODD_AW          = $clog2(ODD_DEPTH);
    localparam int ROM_W           = 15;

    // datapath widths and codes
    localparam int PCODE_W      = 8;
    localparam int SCALE_W      = 16;
    localparam int PROD_W       = PCODE_W + SCALE_W;
    localparam int D_W          = 22;
    localparam int FLOOR_Q8     = -5120;
    localparam int RANGE_Q8     = 30720;
    localparam int RANGE_W      = $clog2(RANGE_Q8);
    localparam int CODE_W       = 8;
    localparam int CODE_TOP     = 254;
    localparam int CODE_MISSING = 255;

    // floor(s*254/30720) = floor(floor(s*127/1024)/15)
    localparam int CODE_NUM       = CODE_TOP / 2;
    localparam int NUM_W          = $clog2(CODE_NUM + 1);
    localparam int CODE_DEN_SHIFT = 10;
    localparam int Y_W            = RANGE_W + NUM_W - CODE_DEN_SHIFT;
    localparam int DIV15_MUL      = 4370;
    localparam int DIV15_W        = $clog2(DIV15_MUL + 1);
    localparam int DIV15_SHIFT    = 16;

    // pipeline
    localparam int PIPE_DEPTH = 7;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 2);

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_SCALE        = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_BIAS         = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_MISSING_CODE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEVEL        = 8'd3;

    localparam logic [SCALE_W-1:0]        RST_POWER_SCALE   = 16'd4096;
    localparam logic signed [15:0]        RST_POWER_BIAS    = 16'sd0;
    localparam logic [PCODE_W-1:0]        RST_MISSING_CODE  = 8'd255;
    localparam logic signed [15:0]        RST_NOISE_LEVEL   = -16'sd25600;

    // table build constants
    localparam logic [63:0] LOG2TEN_TENTH_Q32 = 64'd1426757253;
    localparam logic [63:0] LN2_Q30           = 64'd744261118;
    localparam longint      TENLOG10_2_Q16    = 197283;
    localparam logic [63:0] ONE_Q30           = 64'd1 << 30;

    typedef struct packed {
        logic last;
        logic miss;
    } tag_t;

    // SNR in 1/256 dB at x = k*32/SNR_TABLE_DEPTH dB; evaluated at elaboration
    function automatic logic signed [ROM_W-1:0] rom_entry(input int unsigned k);
        logic [63:0] a;
        logic [63:0] f;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] plus;
        logic [63:0] minus;
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] m;
        logic [63:0] xq;
        int unsigned n;
        int unsigned e;
        int unsigned frac;
        longint lg;
        longint total;
        longint r;
        a = (64'(k) * 64'd32 * LOG2TEN_TENTH_Q32) / 64'(SNR_TABLE_DEPTH);
        n = 32'(a >> 32);
        f = a & 64'hFFFF_FFFF;
        z = (f * LN2_Q30) >> 32;
        term = ONE_Q30;
        plus = ONE_Q30;
        minus = 64'd0;
        for (int i = 1; i <= 16; i++) begin
            term = ((term * z) >> 30) / 64'(i);
            if ((i % 2) == 1) begin
                minus = minus + term;
            end else begin
                plus = plus + term;
            end
        end
        u = (plus > minus) ? plus - minus : 64'd0;
        u = (n < 62) ? (u >> n) : 64'd0;
        if (u >= ONE_Q30) begin
            return ROM_W'(FLOOR_Q8);
        end
        v = ONE_Q30 - u;
        e = 0;
        for (int j = 0; j < 29; j++) begin
            if ((v >> (e + 1)) != 64'd0) begin
                e = e + 1;
            end
        end
        m = v << (30 - e);
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 2 * ONE_Q30) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        lg = longint'(frac) - (longint'(30 - e) << 16);
        xq = (64'(k) * 64'(SPAN_Q8) * (64'd1 << 24)) / 64'(SNR_TABLE_DEPTH);
        total = longint'(xq) + lg * TENLOG10_2_Q16;
        r = total >>> 24;
        if (r < longint'(FLOOR_Q8)) begin
            r = longint'(FLOOR_Q8);
        end
        return ROM_W'(r);
    endfunction

endpackage

`default_nettype wire

### rtl/power_code_to_snr_code_core.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+------------------------------------
// input     | in        | s_valid / s_ready    | s_power_code[7:0], s_last_gate
// result    | out       | m_valid / m_ready    | m_snr_code[7:0], m_last_gate_out
// config    | in        | cfg_valid / cfg_ready| cfg_index[7:0], cfg_data[15:0]
//
// One request per cycle sustained while m_ready is high.
// Seven register stages: code*scale, excess over noise, table read (even/odd ROM banks),
// interpolation product, SNR select, requantise scaling, output code.
// Reset clears the stage valid bits and loads the register defaults; no clearing pass.
// Each stage holds only when it is full and the stage after it holds, so bubbles
// collapse and a stalled result does not block s_ready while a stage is empty.
`default_nettype none

module power_code_to_snr_code_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [ptsc_pkg::PCODE_W-1:0]        s_power_code,
    input  wire logic                                s_last_gate,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [ptsc_pkg::CODE_W-1:0]              m_snr_code,
    output logic                                     m_last_gate_out,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ptsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ptsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration registers
    logic [ptsc_pkg::SCALE_W-1:0]  power_scale_reg;
    logic signed [15:0]            power_bias_reg;
    logic [ptsc_pkg::PCODE_W-1:0]  power_missing_code_reg;
    logic signed [15:0]            noise_level_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_scale_reg        <= ptsc_pkg::RST_POWER_SCALE;
            power_bias_reg         <= ptsc_pkg::RST_POWER_BIAS;
            power_missing_code_reg <= ptsc_pkg::RST_MISSING_CODE;
            noise_level_reg        <= ptsc_pkg::RST_NOISE_LEVEL;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ptsc_pkg::CFG_POWER_SCALE: begin
                    power_scale_reg <= cfg_data;
                end
                ptsc_pkg::CFG_POWER_BIAS: begin
                    power_bias_reg <= signed'(cfg_data);
                end
                ptsc_pkg::CFG_POWER_MISSING_CODE: begin
                    power_missing_code_reg <= cfg_data[ptsc_pkg::PCODE_W-1:0];
                end
                ptsc_pkg::CFG_NOISE_LEVEL: begin
                    noise_level_reg <= signed'(cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    // constant SNR table, split into even and odd entries so that T[i] and T[i+1]
    // each come from a bank of their own
    logic signed [ptsc_pkg::ROM_W-1:0] rom_even [ptsc_pkg::EVEN_DEPTH];
    logic signed [ptsc_pkg::ROM_W-1:0] rom_odd  [ptsc_pkg::ODD_DEPTH];

    for (genvar g = 0; g < ptsc_pkg::EVEN_DEPTH; g++) begin : g_even
        localparam logic signed [ptsc_pkg::ROM_W-1:0] VAL = ptsc_pkg::rom_entry(2 * g);
        assign rom_even[g] = VAL;
    end
    for (genvar g = 0; g < ptsc_pkg::ODD_DEPTH; g++) begin : g_odd
        localparam logic signed [ptsc_pkg::ROM_W-1:0] VAL = ptsc_pkg::rom_entry(2 * g + 1);
        assign rom_odd[g] = VAL;
    end

    // stage valid bits and load enables
    logic [ptsc_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic [ptsc_pkg::PIPE_DEPTH-1:0] vld_next;
    logic [ptsc_pkg::PIPE_DEPTH-1:0] ld;

    always_comb begin
        ld[ptsc_pkg::PIPE_DEPTH-1] = !vld_reg[ptsc_pkg::PIPE_DEPTH-1] || m_ready;
        for (int k = ptsc_pkg::PIPE_DEPTH - 2; k >= 0; k--) begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
        vld_next = vld_reg;
        for (int k = 0; k < ptsc_pkg::PIPE_DEPTH; k++) begin
            if (ld[k]) begin
                vld_next[k] = (k == 0) ? s_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = ld[0];
    assign m_valid = vld_reg[ptsc_pkg::PIPE_DEPTH-1];

    // stage 1: code times scale
    logic [ptsc_pkg::PROD_W-1:0] st1_prod_reg;
    ptsc_pkg::tag_t              st1_tag_reg;

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            st1_prod_reg     <= ptsc_pkg::PROD_W'(s_power_code) *
                                ptsc_pkg::PROD_W'(power_scale_reg);
            st1_tag_reg.miss <= (s_power_code == power_missing_code_reg);
            st1_tag_reg.last <= s_last_gate;
        end
    end

    // stage 2: excess over noise and its class
    logic signed [ptsc_pkg::D_W-1:0] st2_d_next;
    logic signed [ptsc_pkg::D_W-1:0] st2_d_reg;
    logic                            st2_le0_reg;
    logic                            st2_big_reg;
    ptsc_pkg::tag_t                  st2_tag_reg;

    assign st2_d_next = signed'({2'b00, st1_prod_reg[ptsc_pkg::PROD_W-1:4]}) +
                        ptsc_pkg::D_W'(power_bias_reg) - ptsc_pkg::D_W'(noise_level_reg);

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            st2_d_reg   <= st2_d_next;
            st2_le0_reg <= st2_d_next[ptsc_pkg::D_W-1] || (st2_d_next == '0);
            st2_big_reg <= !st2_d_next[ptsc_pkg::D_W-1] &&
                           (st2_d_next[ptsc_pkg::D_W-1:ptsc_pkg::FRAC_W] != '0);
            st2_tag_reg <= st1_tag_reg;
        end
    end

    // stage 3: table position and bank reads
    logic [ptsc_pkg::POS_W-1:0]   pos;
    logic [ptsc_pkg::IDX_W-1:0]   idx;
    logic [ptsc_pkg::EVEN_AW-1:0] even_addr;
    logic [ptsc_pkg::ODD_AW-1:0]  odd_addr;

    assign pos = ptsc_pkg::POS_W'(st2_d_reg[ptsc_pkg::FRAC_W-1:0]) *
                 ptsc_pkg::POS_W'(ptsc_pkg::SNR_TABLE_DEPTH);
    assign idx = pos[ptsc_pkg::POS_W-1:ptsc_pkg::FRAC_W];
    assign even_addr = ptsc_pkg::EVEN_AW'(idx[ptsc_pkg::IDX_W-1:1]) +
                       ptsc_pkg::EVEN_AW'(idx[0]);
    assign odd_addr  = ptsc_pkg::ODD_AW'(idx[ptsc_pkg::IDX_W-1:1]);

    logic signed [ptsc_pkg::ROM_W-1:0] st3_even_reg;
    logic signed [ptsc_pkg::ROM_W-1:0] st3_odd_reg;
    logic                              st3_par_reg;
    logic [ptsc_pkg::FRAC_W-1:0]       st3_fr_reg;
    logic signed [ptsc_pkg::D_W-1:0]   st3_d_reg;
    logic                              st3_le0_reg;
    logic                              st3_big_reg;
    ptsc_pkg::tag_t                    st3_tag_reg;

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            st3_even_reg <= rom_even[even_addr];
            st3_odd_reg  <= rom_odd[odd_addr];
            st3_par_reg  <= idx[0];
            st3_fr_reg   <= pos[ptsc_pkg::FRAC_W-1:0];
            st3_d_reg    <= st2_d_reg;
            st3_le0_reg  <= st2_le0_reg;
            st3_big_reg  <= st2_big_reg;
            st3_tag_reg  <= st2_tag_reg;
        end
    end

    // stage 4: slope times fraction
    logic signed [ptsc_pkg::ROM_W-1:0]                 t0;
    logic signed [ptsc_pkg::ROM_W-1:0]                 t1;
    logic signed [ptsc_pkg::ROM_W:0]                   diff;
    logic signed [ptsc_pkg::ROM_W+ptsc_pkg::FRAC_W+1:0] st4_prod_reg;
    logic signed [ptsc_pkg::ROM_W-1:0]                 st4_t0_reg;
    logic signed [ptsc_pkg::D_W-1:0]                   st4_d_reg;
    logic                                              st4_le0_reg;
    logic                                              st4_big_reg;
    ptsc_pkg::tag_t                                    st4_tag_reg;

    assign t0   = st3_par_reg ? st3_odd_reg : st3_even_reg;
    assign t1   = st3_par_reg ? st3_even_reg : st3_odd_reg;
    assign diff = (ptsc_pkg::ROM_W+1)'(t1) - (ptsc_pkg::ROM_W+1)'(t0);

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            st4_prod_reg <= (ptsc_pkg::ROM_W+ptsc_pkg::FRAC_W+2)'(diff) *
                            (ptsc_pkg::ROM_W+ptsc_pkg::FRAC_W+2)'(signed'({1'b0, st3_fr_reg}));
            st4_t0_reg   <= t0;
            st4_d_reg    <= st3_d_reg;
            st4_le0_reg  <= st3_le0_reg;
            st4_big_reg  <= st3_big_reg;
            st4_tag_reg  <= st3_tag_reg;
        end
    end

    // stage 5: pick the SNR in 1/256 dB
    logic signed [ptsc_pkg::D_W-1:0] st5_snr_next;
    logic signed [ptsc_pkg::D_W-1:0] st5_snr_reg;
    ptsc_pkg::tag_t                  st5_tag_reg;

    always_comb begin
        if (st4_le0_reg) begin
            st5_snr_next = ptsc_pkg::D_W'(ptsc_pkg::FLOOR_Q8);
        end else if (st4_big_reg) begin
            st5_snr_next = st4_d_reg;
        end else begin
            st5_snr_next = ptsc_pkg::D_W'(st4_t0_reg) +
                           ptsc_pkg::D_W'(st4_prod_reg >>> ptsc_pkg::FRAC_W);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[4]) begin
            st5_snr_reg <= st5_snr_next;
            st5_tag_reg <= st4_tag_reg;
        end
    end

    // stage 6: offset from -20 dB and scale by 127/1024; never negative
    logic signed [ptsc_pkg::D_W-1:0]            offs;
    logic [ptsc_pkg::RANGE_W+ptsc_pkg::NUM_W-1:0] scaled;
    logic [ptsc_pkg::Y_W-1:0]                   st6_y_reg;
    logic                                       st6_sat_reg;
    ptsc_pkg::tag_t                             st6_tag_reg;

    assign offs   = st5_snr_reg - ptsc_pkg::D_W'(ptsc_pkg::FLOOR_Q8);
    assign scaled = (ptsc_pkg::RANGE_W+ptsc_pkg::NUM_W)'(offs[ptsc_pkg::RANGE_W-1:0]) *
                    (ptsc_pkg::RANGE_W+ptsc_pkg::NUM_W)'(ptsc_pkg::CODE_NUM);

    always_ff @(posedge aclk) begin
        if (ld[5]) begin
            st6_y_reg   <= scaled[ptsc_pkg::RANGE_W+ptsc_pkg::NUM_W-1:ptsc_pkg::CODE_DEN_SHIFT];
            st6_sat_reg <= (offs >= ptsc_pkg::D_W'(ptsc_pkg::RANGE_Q8));
            st6_tag_reg <= st5_tag_reg;
        end
    end

    // stage 7: divide by 15 through the reciprocal, saturate, flag missing
    logic [ptsc_pkg::Y_W+ptsc_pkg::DIV15_W-1:0] quot;
    logic [ptsc_pkg::CODE_W-1:0]                m_snr_code_next;
    logic [ptsc_pkg::CODE_W-1:0]                m_snr_code_reg;
    logic                                       m_last_reg;

    assign quot = (ptsc_pkg::Y_W+ptsc_pkg::DIV15_W)'(st6_y_reg) *
                  (ptsc_pkg::Y_W+ptsc_pkg::DIV15_W)'(ptsc_pkg::DIV15_MUL);

    always_comb begin
        if (st6_tag_reg.miss) begin
            m_snr_code_next = ptsc_pkg::CODE_W'(ptsc_pkg::CODE_MISSING);
        end else if (st6_sat_reg) begin
            m_snr_code_next = ptsc_pkg::CODE_W'(ptsc_pkg::CODE_TOP);
        end else begin
            m_snr_code_next = quot[ptsc_pkg::DIV15_SHIFT +: ptsc_pkg::CODE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[6]) begin
            m_snr_code_reg <= m_snr_code_next;
            m_last_reg     <= st6_tag_reg.last;
        end
    end

    assign m_snr_code      = m_snr_code_reg;
    assign m_last_gate_out = m_last_reg;

endmodule

`default_nettype wire

### rtl/ptsc_checker.sv
`default_nettype none

module ptsc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [ptsc_pkg::CODE_W-1:0]     m_snr_code,
    input wire logic                            m_last_gate_out
);

    // requests accepted and not yet delivered
    logic [ptsc_pkg::CNT_W-1:0] inflight_reg;
    logic [ptsc_pkg::CNT_W-1:0] inflight_next;

    always_comb begin
        inflight_next = inflight_reg;
        if (s_valid && s_ready && !(m_valid && m_ready)) begin
            inflight_next = inflight_reg + ptsc_pkg::CNT_W'(1);
        end else if (!(s_valid && s_ready) && m_valid && m_ready) begin
            inflight_next = inflight_reg - ptsc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_snr_code) && $stable(m_last_gate_out))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != '0)
        else $error("result shown with nothing in flight");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= ptsc_pkg::CNT_W'(ptsc_pkg::PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == '0 |-> s_ready)
        else $error("empty pipeline refuses a request");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == ptsc_pkg::CNT_W'(ptsc_pkg::PIPE_DEPTH) && !m_ready |-> !s_ready)
        else $error("full stalled pipeline takes a request");

endmodule

bind power_code_to_snr_code_core ptsc_checker u_ptsc_checker (.*);

`default_nettype wire
